// ===== sv/nge_pkg.sv =====
// Shared types and constants for the next greater element block.
package nge_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int VALUE_W     = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_POP_FILL,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_init;
      logic pop;
      logic fill;
      logic push;
      logic out_init;
      logic out_next;
      logic clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop_need;
      logic idx_zero;
      logic out_last;
   } status_type;

endpackage

// ===== sv/nge_ctrl.sv =====
// Sequencer for load, stack scan and result drain.
module nge_ctrl
   import nge_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (status.pop_need) state_in = ST_POP_FILL;
            else if (status.idx_zero) state_in = ST_OUT_RD;
         end
         ST_POP_FILL: begin
            state_in = ST_SCAN_CMP;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_tready && status.out_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN_RD: begin
            cmd.scan_init = 1'b1;
         end
         ST_SCAN_CMP: begin
            cmd.pop  = status.pop_need;
            cmd.push = !status.pop_need;
         end
         ST_POP_FILL: begin
            cmd.fill = 1'b1;
         end
         ST_OUT_RD: begin
            cmd.out_init = 1'b1;
         end
         ST_OUT_SEND: begin
            rsp_tvalid   = 1'b1;
            cmd.clear    = rsp_tready && status.out_last;
            cmd.out_next = rsp_tready && !status.out_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/nge_dp.sv =====
// Element, stack and result memories with scan counters and compare.
module nge_dp
   import nge_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [VALUE_W-1:0]  req_tdata,
   output logic [VALUE_W-1:0]  rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [VALUE_W-1:0] elem_mem [MAX_LEN];
   logic [VALUE_W-1:0] stk_mem  [MAX_LEN];
   logic [VALUE_W:0]   res_mem  [MAX_LEN];

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          depth_ff;
   logic                      ovf_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          k_ff;
   logic signed [VALUE_W-1:0] top_ff;
   logic signed [VALUE_W-1:0] elem_rd_ff;
   logic [VALUE_W-1:0]        stk_rd_ff;
   logic [VALUE_W:0]          res_rd_ff;

   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] depth_m1;
   logic [CNT_W-1:0] depth_m2;
   logic [IDX_W-1:0] idx_m1;
   logic [IDX_W-1:0] k_p1;
   logic             full;
   logic             stack_any;
   logic [IDX_W-1:0] elem_raddr;
   logic [VALUE_W:0] res_wdata;

   assign cnt_m1    = count_ff - CNT_W'(1);
   assign depth_m1  = depth_ff - CNT_W'(1);
   assign depth_m2  = depth_ff - CNT_W'(2);
   assign idx_m1    = idx_ff - IDX_W'(1);
   assign k_p1      = k_ff + IDX_W'(1);
   assign full      = (count_ff == CNT_W'(MAX_LEN));
   assign stack_any = (depth_ff != '0);
   assign elem_raddr = cmd.scan_init ? cnt_m1[IDX_W-1:0] : idx_m1;
   assign res_wdata = stack_any ? {1'b1, top_ff} : '0;

   assign status.pop_need = stack_any && (top_ff <= elem_rd_ff);
   assign status.idx_zero = (idx_ff == '0);
   assign status.out_last = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   assign rsp_tdata = res_rd_ff[VALUE_W-1:0];
   assign rsp_tuser = {ovf_ff, res_rd_ff[VALUE_W]};
   assign rsp_tlast = status.out_last;

   // element store: written on load, read by the scan
   always_ff @(posedge clock) begin
      if (cmd.load && !full) elem_mem[count_ff[IDX_W-1:0]] <= req_tdata;
      if (cmd.scan_init || (cmd.push && !status.idx_zero)) begin
         elem_rd_ff <= elem_mem[elem_raddr];
      end
   end

   // stack below the top entry, which lives in top_ff
   always_ff @(posedge clock) begin
      if (cmd.push && stack_any) stk_mem[depth_m1[IDX_W-1:0]] <= top_ff;
      if (cmd.pop && (depth_ff > CNT_W'(1))) stk_rd_ff <= stk_mem[depth_m2[IDX_W-1:0]];
   end

   // result store; its read register is the output register
   always_ff @(posedge clock) begin
      if (cmd.push) res_mem[idx_ff] <= res_wdata;
      if (cmd.out_init) res_rd_ff <= res_mem[IDX_W'(0)];
      else if (cmd.out_next) res_rd_ff <= res_mem[k_p1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         depth_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (full) ovf_ff <= 1'b1;
            else count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan_init) depth_ff <= '0;
         else if (cmd.pop) depth_ff <= depth_m1;
         else if (cmd.push) depth_ff <= depth_ff + CNT_W'(1);
         if (cmd.clear) begin
            count_ff <= '0;
            depth_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) idx_ff <= cnt_m1[IDX_W-1:0];
      else if (cmd.push && !status.idx_zero) idx_ff <= idx_m1;
      if (cmd.push) top_ff <= elem_rd_ff;
      else if (cmd.fill) top_ff <= stk_rd_ff;
      if (cmd.out_init) k_ff <= '0;
      else if (cmd.out_next) k_ff <= k_p1;
   end

endmodule

// ===== sv/next_greater_element.sv =====
// Top level of the next greater element block: sequencer plus datapath.
//
//  channel | direction | tdata            | tuser (low bit up)  | tlast
//  req_    | in        | [31:0] value     | -                   | last
//  rsp_    | out       | [31:0] next_value| found, truncated    | last_result
//
//  Loading accepts requests in idle. After the last request the scan starts,
//  compares each element with the stack top, pops and refills the top while it
//  is not greater (an element is popped at most once), pushes the element and
//  reads the first result; results then drain one per cycle unless stalled.
//  Synchronous reset clears count, depth, overflow flag and the sequencer; no memory clearing pass.
//  The block takes no request while a scan or drain runs; a stall on rsp_ holds
//  the result register.
module next_greater_element
   import nge_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] next_value
   output logic [1:0]         rsp_tuser,   // [0] found, [1] truncated
   output logic               rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   nge_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nge_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while results drain");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("not-found result carries a nonzero value");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("no return to idle after final result");

   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> cmd.fill)
      else $error("stack pop not followed by top refill");
`endif

endmodule
